// ===== hdl/idal_pkg.sv =====
// Shared types and codes for the ID allocator.
package idal_pkg;

    // Fixed widths of the stream and register fields
    localparam int KIND_W  = 2;
    localparam int FIELD_W = 16;
    localparam int ORDER_W = 2;
    localparam int FLAG_W  = 3;

    // Request kinds carried on s_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    // Issue order held in the mode register
    typedef enum logic [ORDER_W-1:0] {
        ORDER_REUSE = 2'd0,
        ORDER_ASC   = 2'd1,
        ORDER_DESC  = 2'd2
    } order_t;

    // Order value after reset
    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_ASC;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;   // a request is accepted this cycle
        logic load;   // the pending result moves to the output register
    } cmd_t;

endpackage

// ===== hdl/id_allocator_with_free_pool.sv =====
// Top level of the ID allocator with a free pool.
//
//  Channel    Direction  Signals                       Contents
//  request    in         s_tvalid/s_tready/s_tdata     freed_id, start_value
//                        s_tuser                       kind
//  result     out        m_tvalid/m_tready/m_tdata     issued_id
//                        m_tuser                       id_valid, fallback_active,
//                                                      pool_overflow
//  mode       in         cfg_wen/cfg_wdata             id_order
//
// Each request passes through a pending stage, so that a popped ID can be
// read from the pool RAM, then moves to the output register that drives
// m_tdata. A new request is taken in the cycle the pending result moves out,
// so the block sustains one request per cycle while the result side keeps
// up. A stall on the result side holds one result in the output register and
// one pending; further requests wait. Reset is asynchronous and needs no
// clearing pass: the pool is empty after reset and only pushed entries are
// read.
module id_allocator_with_free_pool #(
    parameter int ID_BITS    = 16,
    parameter int POOL_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] freed_id, [31:16] start_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] issued_id
    output logic [2:0]  m_tuser,   // [0] id_valid, [1] fallback_active, [2] pool_overflow
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_wdata  // id_order
);

    idal_pkg::cmd_t cmd;

    // Handshake and sequencing
    idal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Counter, pool and result registers
    idal_dp #(
        .ID_BITS    (ID_BITS),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (s_tuser),
        .freed_id    (s_tdata[15:0]),
        .start_value (s_tdata[31:16]),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .issued_id   (m_tdata),
        .flags       (m_tuser)
    );

endmodule

// ===== hdl/idal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module idal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/idal_ctrl.sv =====
// Controller: request handshake, pending-result state and output valid.
module idal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output idal_pkg::cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;
    logic   take;

    // The pending result leaves once the output register is free or draining
    assign load     = (state_reg == ST_BUSY) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) || load;
    assign take     = s_tvalid && s_tready;

    assign cmd.take = take;
    assign cmd.load = load;
    assign m_tvalid = out_valid_reg;

    // Next state and output valid
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (take)
                begin
                    state_next = ST_BUSY;
                end
                else if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted request always leaves a result pending
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg == ST_BUSY)
        else $error("accepted request left no pending result");

    // A pending result that is not moved stays pending
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY && !load) |=> state_reg == ST_BUSY)
        else $error("pending result was lost");

    // A result is only moved into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg) |-> m_tready)
        else $error("output register overwritten");

endmodule

// ===== hdl/idal_dp.sv =====
// Datapath: mode register, ID counter, fallback flag, free pool and result registers.
module idal_dp #(
    parameter int ID_BITS    = 16,
    parameter int POOL_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  idal_pkg::cmd_t                 cmd,
    input  logic [idal_pkg::KIND_W-1:0]    kind,
    input  logic [idal_pkg::FIELD_W-1:0]   freed_id,
    input  logic [idal_pkg::FIELD_W-1:0]   start_value,
    input  logic                           cfg_wen,
    input  logic [idal_pkg::ORDER_W-1:0]   cfg_wdata,
    output logic [idal_pkg::FIELD_W-1:0]   issued_id,
    output logic [idal_pkg::FLAG_W-1:0]    flags
);

    localparam int PTR_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam logic [ID_BITS-1:0] INVALID_ID = '1;
    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(POOL_DEPTH - 1);
    localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(POOL_DEPTH);

    logic [idal_pkg::ORDER_W-1:0] order_reg, order_next;
    logic [ID_BITS-1:0]           ctr_reg, ctr_next;
    logic                         fb_reg, fb_next;
    logic [PTR_W-1:0]             head_reg, head_next;
    logic [PTR_W-1:0]             tail_reg, tail_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [ID_BITS-1:0]           res_id_reg, res_id_next;
    logic                         res_pool_reg, res_pool_next;
    logic                         res_ovf_reg, res_ovf_next;
    logic [idal_pkg::FIELD_W-1:0] issued_id_reg;
    logic [idal_pkg::FLAG_W-1:0]  flags_reg;

    logic                         ram_we;
    logic                         ram_re;
    logic [ID_BITS-1:0]           ram_rdata;
    logic                         pool_empty;
    logic [ID_BITS-1:0]           result_id;
    logic                         result_valid;
    logic [CNT_W-1:0]             occupancy;

    // Pointer advance with wrap at the pool depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign pool_empty = (count_reg == '0);

    // Pool storage
    idal_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ID_BITS'(freed_id)),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Request and register-write processing
    always_comb
    begin
        order_next    = order_reg;
        ctr_next      = ctr_reg;
        fb_next       = fb_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        res_id_next   = res_id_reg;
        res_pool_next = res_pool_reg;
        res_ovf_next  = res_ovf_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (cfg_wen)
        begin
            // Mode write reinitialises pool, counter and fallback flag
            order_next = cfg_wdata;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            ctr_next   = (cfg_wdata == idal_pkg::ORDER_DESC) ? INVALID_ID : '0;
            fb_next    = (cfg_wdata == idal_pkg::ORDER_REUSE);
        end
        else if (cmd.take)
        begin
            res_id_next   = INVALID_ID;
            res_pool_next = 1'b0;
            res_ovf_next  = 1'b0;
            case (kind)
                idal_pkg::KIND_ALLOC:
                begin
                    case (order_reg)
                        idal_pkg::ORDER_REUSE:
                        begin
                            if (!pool_empty)
                            begin
                                ram_re        = 1'b1;
                                res_pool_next = 1'b1;
                                head_next     = ptr_inc(head_reg);
                                count_next    = count_reg - 1'b1;
                            end
                            else if (ctr_reg != INVALID_ID)
                            begin
                                res_id_next = ctr_reg;
                                ctr_next    = ctr_reg + 1'b1;
                            end
                        end
                        idal_pkg::ORDER_ASC:
                        begin
                            if (fb_reg || ctr_reg == INVALID_ID)
                            begin
                                fb_next = 1'b1;
                                if (!pool_empty)
                                begin
                                    ram_re        = 1'b1;
                                    res_pool_next = 1'b1;
                                    head_next     = ptr_inc(head_reg);
                                    count_next    = count_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                res_id_next = ctr_reg;
                                ctr_next    = ctr_reg + 1'b1;
                            end
                        end
                        idal_pkg::ORDER_DESC:
                        begin
                            if (fb_reg || ctr_reg == '0)
                            begin
                                fb_next = 1'b1;
                                if (!pool_empty)
                                begin
                                    ram_re        = 1'b1;
                                    res_pool_next = 1'b1;
                                    head_next     = ptr_inc(head_reg);
                                    count_next    = count_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                res_id_next = ctr_reg - 1'b1;
                                ctr_next    = ctr_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            // Unused order: no ID and no change
                            res_id_next = INVALID_ID;
                        end
                    endcase
                end
                idal_pkg::KIND_FREE:
                begin
                    if (count_reg == CNT_FULL)
                    begin
                        res_ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                idal_pkg::KIND_RESTART:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    ctr_next   = ID_BITS'(start_value);
                    fb_next    = (order_reg == idal_pkg::ORDER_REUSE);
                end
                default:
                begin
                    // Unused kind: nothing changes
                    res_ovf_next = 1'b0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= idal_pkg::ORDER_RESET;
            ctr_reg   <= '0;
            fb_reg    <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            order_reg <= order_next;
            ctr_reg   <= ctr_next;
            fb_reg    <= fb_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Pending result fields
    always_ff @(posedge clk)
    begin
        res_id_reg   <= res_id_next;
        res_pool_reg <= res_pool_next;
        res_ovf_reg  <= res_ovf_next;
    end

    // A popped ID comes from the pool's registered read data, loaded when the request is accepted
    assign result_id    = res_pool_reg ? ram_rdata : res_id_reg;
    assign result_valid = (result_id != INVALID_ID);

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            issued_id_reg <= idal_pkg::FIELD_W'(result_id);
            flags_reg     <= {res_ovf_reg, fb_reg, result_valid};
        end
    end

    assign issued_id = issued_id_reg;
    assign flags     = flags_reg;

    // Entries held between the pointers, modulo the pool depth
    assign occupancy = (tail_reg >= head_reg)
                     ? CNT_W'(tail_reg - head_reg)
                     : CNT_W'(CNT_FULL - CNT_W'(head_reg) + CNT_W'(tail_reg));

    // The fill count never passes the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("pool count beyond depth");

    // Pointers and fill count agree while the pool is not full
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CNT_FULL) |-> (occupancy == count_reg))
        else $error("pool pointers disagree with count");

    // A full pool keeps its pointers level
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_FULL) |-> (head_reg == tail_reg))
        else $error("full pool with unequal pointers");

endmodule
